// ===== rtl/esest_pkg.sv =====
`timescale 1ns / 1ps

package esest_pkg;

  // Width of the speed result and its saturation value.
  localparam int unsigned SpeedW = 31;
  localparam logic [SpeedW-1:0] SpeedMax = {SpeedW{1'b1}};

  // Dividend of the speed quotient: 2^22 ticks per step gives unit speed.
  localparam int unsigned ScaleW = 23;
  localparam logic [ScaleW-1:0] SpeedScale = 23'h400000;

  // Edges since the last update are counted in this many bits.
  localparam int unsigned StepW = 16;

  // Reset value of the stall limit register.
  localparam logic [7:0] StallLimitReset = 8'd64;

  // Values of the action field.
  localparam logic ActSample = 1'b0;
  localparam logic ActUpdate = 1'b1;

  typedef struct packed {
    logic        action;
    logic        enc_level;
    logic [31:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [SpeedW-1:0] speed;
    logic              stalled;
    logic signed [31:0] position;
  } out_item_t;

endpackage

// ===== rtl/encoder_speed_estimator.sv =====
`timescale 1ns / 1ps
// A sample transaction leaves the block ready again on the next cycle.
// Update transactions that divide run 23 steps of the restoring divider, one multiply
// and one output load before the result is valid. Updates that need no division
// (stalled, zero interval) go straight to the output load. The block takes no new
// transaction until an update's result is loaded into the output register;
// a result held back by the receiver delays that load. Reset (asynchronous, active low)
// clears all state but the output data and sets the stall limit to 64.

module encoder_speed_estimator (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  esest_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output esest_pkg::out_item_t out_data_o,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_data_i
);

  // The sequencer: IDLE takes transactions, DIV runs the subtractor once per
  // quotient bit, MUL scales the quotient by the step count, and WRITE waits until
  // the output register is free to take the result.
  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StMul,
    StWrite
  } state_e;

  state_e state_q;

  // Tachometer state.
  logic [7:0]                    stall_limit_q;
  logic                          prev_level_q;
  logic [31:0]                   last_edge_time_q;
  logic [31:0]                   interval_sum_q;
  logic [31:0]                   edge_count_q;
  logic [esest_pkg::StepW-1:0]   count_at_update_q;
  logic [31:0]                   last_interval_q;
  logic                          stall_flag_q;

  // Working registers of the divider and multiplier.
  logic [31:0]                   div_q;
  logic [31:0]                   rem_q;
  logic [esest_pkg::ScaleW-1:0]  quo_q;
  logic [4:0]                    cnt_q;
  logic [esest_pkg::StepW-1:0]   steps_q;
  logic [esest_pkg::SpeedW-1:0]  speed_q;
  logic                          stalled_q;

  // Output register, which decouples the result from the input side.
  logic                          out_valid_q;
  esest_pkg::out_item_t          out_q;

  logic accept;
  logic out_free;

  assign in_stall_o  = (state_q != StIdle);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Decisions taken when an update transaction is accepted.
  logic [31:0]                  elapsed;
  logic [esest_pkg::StepW-1:0]  new_steps;
  logic                         have_edges;
  logic                         stall_hit;
  logic                         stall_next;
  logic [esest_pkg::StepW-1:0]  eff_steps;
  logic [31:0]                  eff_interval;

  always_comb begin
    elapsed    = in_data_i.now_time - last_edge_time_q;
    new_steps  = edge_count_q[esest_pkg::StepW-1:0] - count_at_update_q;
    have_edges = (new_steps != '0);
    // The stall test only runs while the flag is clear; once set it holds until
    // an update sees new edges.
    stall_hit  = !stall_flag_q && (elapsed[31:16] > {8'd0, stall_limit_q});
    stall_next = have_edges ? 1'b0 : (stall_flag_q || stall_hit);
    if (have_edges) begin
      eff_steps    = new_steps;
      eff_interval = interval_sum_q;
    end else begin
      // Without edges, the elapsed time stands in for one step, but the speed
      // may not rise above what the last measured interval gave.
      eff_steps    = stall_next ? '0 : esest_pkg::StepW'(1);
      eff_interval = (elapsed < last_interval_q) ? last_interval_q : elapsed;
    end
  end

  // One step of the restoring divider: bring down the next dividend bit and
  // subtract the divisor if it fits.
  logic [32:0] trial;
  logic        fits;
  logic [32:0] diff;

  always_comb begin
    trial = {rem_q, esest_pkg::SpeedScale[cnt_q]};
    fits  = (trial >= {1'b0, div_q});
    diff  = trial - {1'b0, div_q};
  end

  // Scaling of the quotient by the step count, saturated to the speed width.
  logic [esest_pkg::StepW+esest_pkg::ScaleW-1:0] prod;

  assign prod = steps_q * quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= StIdle;
      stall_limit_q     <= esest_pkg::StallLimitReset;
      prev_level_q      <= 1'b0;
      last_edge_time_q  <= '0;
      interval_sum_q    <= '0;
      edge_count_q      <= '0;
      count_at_update_q <= '0;
      last_interval_q   <= '0;
      stall_flag_q      <= 1'b0;
      out_valid_q       <= 1'b0;
      cnt_q             <= '0;
      div_q             <= '0;
      rem_q             <= '0;
      quo_q             <= '0;
      steps_q           <= '0;
      speed_q           <= '0;
      stalled_q         <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        stall_limit_q <= cfg_data_i;
      end
      // A result taken by the receiver frees the register, unless a new one is
      // loaded at the same edge.
      if (out_valid_q && !out_stall_i && state_q != StWrite) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        StIdle: begin
          if (accept && in_data_i.action == esest_pkg::ActSample) begin
            // Any level change is remembered; only a rising edge counts.
            if (in_data_i.enc_level != prev_level_q) begin
              prev_level_q <= in_data_i.enc_level;
              if (in_data_i.enc_level) begin
                interval_sum_q   <= interval_sum_q + elapsed;
                last_edge_time_q <= in_data_i.now_time;
                edge_count_q     <= edge_count_q + 32'd1;
              end
            end
          end else if (accept) begin
            interval_sum_q    <= '0;
            count_at_update_q <= edge_count_q[esest_pkg::StepW-1:0];
            stall_flag_q      <= stall_next;
            stalled_q         <= stall_next;
            if (have_edges) begin
              last_interval_q <= interval_sum_q;
            end
            steps_q <= eff_steps;
            div_q   <= eff_interval;
            rem_q   <= '0;
            quo_q   <= '0;
            cnt_q   <= 5'(esest_pkg::ScaleW - 1);
            // No steps means speed zero; a zero interval saturates.
            if (eff_steps == '0) begin
              speed_q <= '0;
              state_q <= StWrite;
            end else if (eff_interval == '0) begin
              speed_q <= esest_pkg::SpeedMax;
              state_q <= StWrite;
            end else begin
              state_q <= StDiv;
            end
          end
        end

        StDiv: begin
          rem_q <= fits ? diff[31:0] : trial[31:0];
          quo_q <= {quo_q[esest_pkg::ScaleW-2:0], fits};
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == '0) begin
            state_q <= StMul;
          end
        end

        StMul: begin
          if (prod > {{(esest_pkg::StepW+esest_pkg::ScaleW-esest_pkg::SpeedW){1'b0}},
                      esest_pkg::SpeedMax}) begin
            speed_q <= esest_pkg::SpeedMax;
          end else begin
            speed_q <= prod[esest_pkg::SpeedW-1:0];
          end
          state_q <= StWrite;
        end

        StWrite: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end

        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // The position cannot change while an update is in flight, so it is taken
  // straight from the edge counter when the result is loaded.
  always_ff @(posedge clk_i) begin
    if (state_q == StWrite && out_free) begin
      out_q.speed    <= speed_q;
      out_q.stalled  <= stalled_q;
      out_q.position <= $signed(edge_count_q);
    end
  end

endmodule

// ===== rtl/esest_checker.sv =====
`timescale 1ns / 1ps

module esest_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input esest_pkg::in_item_t  in_data_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input esest_pkg::out_item_t out_data_o,
  input logic                 cfg_we_i,
  input logic [7:0]           cfg_data_i
);

  // An update keeps the block busy on the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.action == esest_pkg::ActUpdate
    |=> in_stall_o)
    else $error("block ready straight after an update transaction");

  // A sample leaves the block ready on the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.action == esest_pkg::ActSample
    |=> !in_stall_o)
    else $error("block busy after a sample transaction");

  // A stalled result reports zero speed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.stalled |-> out_data_o.speed == '0)
    else $error("stalled result with nonzero speed");

  // A result that waits stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("waiting result dropped or changed");

endmodule

bind encoder_speed_estimator esest_checker u_checker (.*);
